### rtl/mpt_pkg.sv
// shared constants for the mixture pressure and temperature core
package mpt_pkg;

  localparam int SPECIES_MAX       = 4;
  localparam int FRAC_BITS_DEFAULT = 24;

  localparam int GAMMA_W = 26;
  localparam int GAS_W   = 47;
  localparam int MOM_W   = 48;
  localparam int DENS_W  = 47;
  localparam int RHO_W   = DENS_W + 2;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 47;
  localparam int SEL_W   = IDX_W - 1;

  localparam int IN_W  = 336;
  localparam int OUT_W = 144;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 26'd23488102;
  localparam logic [GAS_W-1:0]   GAS_RESET   = 47'd4815060992;

  // low bit of the register index picks the kind
  localparam logic REG_GAMMA = 1'b0;
  localparam logic REG_GAS   = 1'b1;

  localparam logic [MOM_W-1:0]  MAG_POS_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [MOM_W-1:0]  MAG_NEG_MAX  = 48'h8000_0000_0000;
  localparam logic [DENS_W-1:0] DENS_MAX     = 47'h7FFF_FFFF_FFFF;

endpackage

### rtl/mpt_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module mpt_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          vld [NW+1];
  logic [DW-1:0] rem [NW+1];
  logic [NW-1:0] nq  [NW+1];
  logic [DW-1:0] dv  [NW+1];
  logic [SW-1:0] sd  [NW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      nq[0]  <= num;
      dv[0]  <= den;
      sd[0]  <= side;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // dividend bits shift out of the top while quotient bits enter below
    assign trial = {rem[i], nq[i][NW-1]};
    assign diff  = trial - {1'b0, dv[i]};
    assign ge    = trial >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq[i+1]  <= {nq[i][NW-2:0], ge};
        dv[i+1]  <= dv[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[NW];
  assign quo       = nq[NW];
  assign side_out  = sd[NW];

endmodule

### rtl/mixture_pressure_temperature_core.sv
// top level of the ideal gas mixture pressure and temperature core
// One cell enters per cycle while the result side is not stalled, and results leave in the same
// order; the path runs through three one-bit-per-stage dividers for kinetic energy, gamma minus
// one and temperature. The per-species R/(gamma-1) terms come from free-running dividers that
// settle after a register write. A stall on the result side holds the whole pipeline; the input
// register still takes a request when empty.
module mixture_pressure_temperature_core #(
  parameter int MAX_SPECIES = mpt_pkg::SPECIES_MAX,
  parameter int FRAC_BITS   = mpt_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // momentum_x, momentum_y, total_energy, density_a, density_b, density_c, density_d, pad
  input  logic [mpt_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // mixture_density, pressure, temperature, pad
  output logic [mpt_pkg::OUT_W-1:0]  m_tdata,
  // error_flag
  output logic                       m_tuser,
  input  logic                       cfg_wen,
  input  logic [mpt_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mpt_pkg::CFG_W-1:0]  cfg_data
);

  localparam int F     = FRAC_BITS;
  localparam int NS    = MAX_SPECIES;
  localparam int MW    = mpt_pkg::MOM_W;
  localparam int DN    = mpt_pkg::DENS_W;
  localparam int GW    = mpt_pkg::GAMMA_W;
  localparam int RW    = mpt_pkg::GAS_W;
  localparam int RHW   = mpt_pkg::RHO_W;
  localparam int ML    = MW / 2;
  localparam int MH    = MW - ML;
  localparam int DL    = DN / 2;
  localparam int DH    = DN - DL;
  localparam int KW    = RW + F;
  localparam int KL    = KW / 2;
  localparam int KH    = KW - KL;
  localparam int PRW   = DN + RW;
  localparam int WW    = PRW + 2;
  localparam int SQW   = 2 * MW;
  localparam int EW    = SQW + 1;
  localparam int DKW   = DN + KW;
  localparam int VW    = DKW + 2;
  localparam int GNW   = WW + F;
  localparam int HW    = 64;
  localparam int HL    = HW / 2;
  localparam int PW    = 2 * HW;
  localparam int TNW   = MW + 2 * F;
  localparam int DLSB  = 3 * MW;
  localparam int SWK   = NS * DN + MW + 1 + RHW + WW;
  localparam int SWG   = 1 + EW + 1 + RHW + WW;
  localparam int SWT   = MW + 2 + RHW;
  localparam logic [33:0] ONE_X = 34'd1 << F;

  logic en;
  assign en = !m_tvalid || m_tready;

  // configuration registers
  logic [GW-1:0] gam [NS];
  logic [RW-1:0] gas [NS];
  logic [GW-1:0] a_c [NS];
  logic [KW-1:0] kq  [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) begin
        gam[s] <= mpt_pkg::GAMMA_RESET;
        gas[s] <= mpt_pkg::GAS_RESET;
      end
    end else if (cfg_wen) begin
      for (int s = 0; s < NS; s++) begin
        if (cfg_index[mpt_pkg::IDX_W-1:1] == mpt_pkg::SEL_W'(s)) begin
          if (cfg_index[0] == mpt_pkg::REG_GAMMA) begin
            gam[s] <= cfg_data[GW-1:0];
          end else begin
            gas[s] <= cfg_data[RW-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    logic [33:0] gx;
    gx = '0;
    for (int s = 0; s < NS; s++) begin
      gx = 34'(gam[s]);
      a_c[s] = (gx > ONE_X) ? GW'(gx - ONE_X) : GW'(1);
    end
  end

  // R/(gamma-1) per species, recomputed every cycle from the registers
  for (genvar s = 0; s < NS; s++) begin : g_kdiv
    mpt_div #(.NW(KW), .DW(GW), .SW(1)) u_kdiv (
      .clk      (clk),
      .rst      (rst),
      .en       (1'b1),
      .in_valid (1'b1),
      .num      ({gas[s], {F{1'b0}}}),
      .den      (a_c[s]),
      .side     (1'b0),
      .out_valid(),
      .quo      (kq[s]),
      .side_out ()
    );
  end

  // input register
  logic                       v0;
  logic                       ld0;
  logic [mpt_pkg::IN_W-1:0]   d0;

  assign ld0      = en || !v0;
  assign s_tready = ld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ld0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      d0 <= s_tdata;
    end
  end

  // magnitudes and density sum
  logic [MW-1:0]    fld   [3];
  logic [MW-1:0]    mag_c [3];
  logic [RHW-1:0]   rho_c;
  logic [NS*DN-1:0] dens_c;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fld[j]   = d0[j*MW +: MW];
      mag_c[j] = fld[j][MW-1] ? (MW'(0) - fld[j]) : fld[j];
    end
    dens_c = d0[DLSB +: NS*DN];
    rho_c  = '0;
    for (int s = 0; s < NS; s++) begin
      rho_c = rho_c + RHW'(dens_c[s*DN +: DN]);
    end
  end

  logic             v1;
  logic [MW-1:0]    mag1 [3];
  logic             eneg1;
  logic [NS*DN-1:0] dens1;
  logic [RHW-1:0]   rho1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag1[j] <= mag_c[j];
      end
      eneg1 <= fld[2][MW-1];
      dens1 <= dens_c;
      rho1  <= rho_c;
    end
  end

  // partial products of the momentum squares and of density times gas constant
  logic             va;
  logic [2*MH-1:0]  pp_sq [2][4];
  logic [2*DH-1:0]  pp_dr [NS][4];
  logic [RHW-1:0]   rhoA;
  logic [MW-1:0]    emagA;
  logic             enegA;
  logic [NS*DN-1:0] densA;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        pp_sq[j][0] <= (2*MH)'(mag1[j][ML-1:0]) * (2*MH)'(mag1[j][ML-1:0]);
        pp_sq[j][1] <= (2*MH)'(mag1[j][ML-1:0]) * (2*MH)'(mag1[j][MW-1:ML]);
        pp_sq[j][2] <= (2*MH)'(mag1[j][MW-1:ML]) * (2*MH)'(mag1[j][ML-1:0]);
        pp_sq[j][3] <= (2*MH)'(mag1[j][MW-1:ML]) * (2*MH)'(mag1[j][MW-1:ML]);
      end
      for (int s = 0; s < NS; s++) begin
        pp_dr[s][0] <= (2*DH)'(dens1[s*DN +: DL]) * (2*DH)'(gas[s][DL-1:0]);
        pp_dr[s][1] <= (2*DH)'(dens1[s*DN +: DL]) * (2*DH)'(gas[s][RW-1:DL]);
        pp_dr[s][2] <= (2*DH)'(dens1[s*DN+DL +: DH]) * (2*DH)'(gas[s][DL-1:0]);
        pp_dr[s][3] <= (2*DH)'(dens1[s*DN+DL +: DH]) * (2*DH)'(gas[s][RW-1:DL]);
      end
      rhoA  <= rho1;
      emagA <= mag1[2];
      enegA <= eneg1;
      densA <= dens1;
    end
  end

  logic             vb;
  logic [SQW-1:0]   sqB [2];
  logic [PRW-1:0]   drB [NS];
  logic [RHW-1:0]   rhoB;
  logic [MW-1:0]    emagB;
  logic             enegB;
  logic [NS*DN-1:0] densB;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        sqB[j] <= SQW'(pp_sq[j][0]) + (SQW'(pp_sq[j][1]) << ML)
                + (SQW'(pp_sq[j][2]) << ML) + (SQW'(pp_sq[j][3]) << (2*ML));
      end
      for (int s = 0; s < NS; s++) begin
        drB[s] <= PRW'(pp_dr[s][0]) + (PRW'(pp_dr[s][1]) << DL)
                + (PRW'(pp_dr[s][2]) << DL) + (PRW'(pp_dr[s][3]) << (2*DL));
      end
      rhoB  <= rhoA;
      emagB <= emagA;
      enegB <= enegA;
      densB <= densA;
    end
  end

  // kinetic energy: (mx^2 + my^2) / (2 rho)
  logic [WW-1:0]  wsumB;
  logic [SQW-1:0] numK;
  logic [SWK-1:0] sideK;

  always_comb begin
    wsumB = '0;
    for (int s = 0; s < NS; s++) begin
      wsumB = wsumB + WW'(drB[s]);
    end
    numK  = sqB[0] + sqB[1];
    sideK = {densB, emagB, enegB, rhoB, wsumB};
  end

  logic           vk;
  logic [SQW-1:0] qk;
  logic [SWK-1:0] sok;

  mpt_div #(.NW(SQW), .DW(RHW + 1), .SW(SWK)) u_kin_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vb),
    .num      (numK),
    .den      ({rhoB, 1'b0}),
    .side     (sideK),
    .out_valid(vk),
    .quo      (qk),
    .side_out (sok)
  );

  logic [WW-1:0]    wK;
  logic [RHW-1:0]   rhoK;
  logic             enegK;
  logic [MW-1:0]    emagK;
  logic [NS*DN-1:0] densK;
  logic [EW-1:0]    emx;
  logic [EW-1:0]    kx;
  logic [EW-1:0]    e_c;
  logic             eneg_c;

  always_comb begin
    wK    = sok[WW-1:0];
    rhoK  = sok[WW +: RHW];
    enegK = sok[WW+RHW];
    emagK = sok[WW+RHW+1 +: MW];
    densK = sok[WW+RHW+1+MW +: NS*DN];
    emx   = EW'(emagK);
    kx    = EW'(qk);
    if (enegK) begin
      e_c    = emx + kx;
      eneg_c = 1'b1;
    end else if (emx >= kx) begin
      e_c    = emx - kx;
      eneg_c = 1'b0;
    end else begin
      e_c    = kx - emx;
      eneg_c = 1'b1;
    end
  end

  // partial products of density times R/(gamma-1)
  logic             vc;
  logic [DH+KH-1:0] pp_dk [NS][4];
  logic [EW-1:0]    eC;
  logic             enegC;
  logic [RHW-1:0]   rhoC;
  logic [WW-1:0]    wC;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vk;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        pp_dk[s][0] <= (DH+KH)'(densK[s*DN +: DL]) * (DH+KH)'(kq[s][KL-1:0]);
        pp_dk[s][1] <= (DH+KH)'(densK[s*DN +: DL]) * (DH+KH)'(kq[s][KW-1:KL]);
        pp_dk[s][2] <= (DH+KH)'(densK[s*DN+DL +: DH]) * (DH+KH)'(kq[s][KL-1:0]);
        pp_dk[s][3] <= (DH+KH)'(densK[s*DN+DL +: DH]) * (DH+KH)'(kq[s][KW-1:KL]);
      end
      eC    <= e_c;
      enegC <= eneg_c;
      rhoC  <= rhoK;
      wC    <= wK;
    end
  end

  logic           vd;
  logic [DKW-1:0] dkD [NS];
  logic [EW-1:0]  eD;
  logic           enegD;
  logic [RHW-1:0] rhoD;
  logic [WW-1:0]  wD;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        dkD[s] <= DKW'(pp_dk[s][0]) + (DKW'(pp_dk[s][1]) << KL)
                + (DKW'(pp_dk[s][2]) << DL) + (DKW'(pp_dk[s][3]) << (DL+KL));
      end
      eD    <= eC;
      enegD <= enegC;
      rhoD  <= rhoC;
      wD    <= wC;
    end
  end

  // gamma minus one: W * 2^F / V
  logic [VW-1:0]  vsum;
  logic [SWG-1:0] sideG;

  always_comb begin
    vsum = '0;
    for (int s = 0; s < NS; s++) begin
      vsum = vsum + VW'(dkD[s]);
    end
    sideG = {(vsum == '0), eD, enegD, rhoD, wD};
  end

  logic           vg;
  logic [GNW-1:0] qg;
  logic [SWG-1:0] sog;

  mpt_div #(.NW(GNW), .DW(VW), .SW(SWG)) u_gam_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vd),
    .num      ({wD, {F{1'b0}}}),
    .den      (vsum),
    .side     (sideG),
    .out_valid(vg),
    .quo      (qg),
    .side_out (sog)
  );

  logic [WW-1:0]  wG;
  logic [RHW-1:0] rhoG;
  logic           enegG;
  logic [EW-1:0]  eG;
  logic           vzG;
  logic [HW-1:0]  gm1;

  always_comb begin
    wG    = sog[WW-1:0];
    rhoG  = sog[WW +: RHW];
    enegG = sog[WW+RHW];
    eG    = sog[WW+RHW+1 +: EW];
    vzG   = sog[WW+RHW+1+EW];
    gm1   = (vzG || (|qg[GNW-1:HW])) ? '1 : qg[HW-1:0];
  end

  // energy times gamma minus one
  logic           ve;
  logic [PW/2-1:0] pp_g [4];
  logic           ebigE;
  logic           pzeroE;
  logic           enegE;
  logic [RHW-1:0] rhoE;
  logic [WW-1:0]  wE;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_g[0] <= (PW/2)'(eG[HL-1:0]) * (PW/2)'(gm1[HL-1:0]);
      pp_g[1] <= (PW/2)'(eG[HL-1:0]) * (PW/2)'(gm1[HW-1:HL]);
      pp_g[2] <= (PW/2)'(eG[HW-1:HL]) * (PW/2)'(gm1[HL-1:0]);
      pp_g[3] <= (PW/2)'(eG[HW-1:HL]) * (PW/2)'(gm1[HW-1:HL]);
      ebigE   <= |eG[EW-1:HW];
      pzeroE  <= (gm1 == '0) || (eG == '0);
      enegE   <= enegG;
      rhoE    <= rhoG;
      wE      <= wG;
    end
  end

  logic           vf;
  logic [PW-1:0]  prodF;
  logic           ebigF;
  logic           pzeroF;
  logic           enegF;
  logic [RHW-1:0] rhoF;
  logic [WW-1:0]  wF;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prodF  <= PW'(pp_g[0]) + (PW'(pp_g[1]) << HL) + (PW'(pp_g[2]) << HL)
              + (PW'(pp_g[3]) << HW);
      ebigF  <= ebigE;
      pzeroF <= pzeroE;
      enegF  <= enegE;
      rhoF   <= rhoE;
      wF     <= wE;
    end
  end

  // saturated pressure magnitude, then temperature: p * 2^(2F) / W
  logic [MW-1:0]  plim;
  logic [MW-1:0]  pmag;
  logic [SWT-1:0] sideT;

  always_comb begin
    plim = enegF ? mpt_pkg::MAG_NEG_MAX : mpt_pkg::MAG_POS_MAX;
    if (pzeroF) begin
      pmag = '0;
    end else if (ebigF || (prodF[PW-1:F] > (PW-F)'(plim))) begin
      pmag = plim;
    end else begin
      pmag = prodF[F +: MW];
    end
    sideT = {pmag, enegF, (wF == '0), rhoF};
  end

  logic           vt;
  logic [TNW-1:0] qt;
  logic [SWT-1:0] sot;

  mpt_div #(.NW(TNW), .DW(WW), .SW(SWT)) u_tmp_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vf),
    .num      ({pmag, {(2*F){1'b0}}}),
    .den      (wF),
    .side     (sideT),
    .out_valid(vt),
    .quo      (qt),
    .side_out (sot)
  );

  logic [RHW-1:0] rhoT;
  logic           wzT;
  logic           enegT;
  logic [MW-1:0]  pmagT;
  logic           tneg;
  logic [MW-1:0]  tlim;
  logic [MW-1:0]  tmag;
  logic [DN-1:0]  dens_o;
  logic [MW-1:0]  pres_o;
  logic [MW-1:0]  temp_o;
  logic           err_o;

  always_comb begin
    rhoT  = sot[RHW-1:0];
    wzT   = sot[RHW];
    enegT = sot[RHW+1];
    pmagT = sot[RHW+2 +: MW];
    tneg  = enegT && (pmagT != '0);
    tlim  = tneg ? mpt_pkg::MAG_NEG_MAX : mpt_pkg::MAG_POS_MAX;
    tmag  = (qt > TNW'(tlim)) ? tlim : qt[MW-1:0];
    dens_o = (rhoT > RHW'(mpt_pkg::DENS_MAX)) ? mpt_pkg::DENS_MAX : rhoT[DN-1:0];
    pres_o = enegT ? (MW'(0) - pmagT) : pmagT;
    temp_o = tneg ? (MW'(0) - tmag) : tmag;
    err_o  = 1'b0;
    if (rhoT == '0) begin
      dens_o = '0;
      pres_o = '0;
      temp_o = '0;
      err_o  = 1'b1;
    end else if (wzT) begin
      pres_o = '0;
      temp_o = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, temp_o, pres_o, dens_o};
      m_tuser <= err_o;
    end
  end

endmodule

### rtl/mpt_checker.sv
// port checks for the mixture pressure and temperature core, bound to the top level
module mpt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [mpt_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tuser
);

  // a waiting result stays
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // zero density gives an all-zero result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error result carries data");

  // without the error flag the density is not zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[mpt_pkg::DENS_W-1:0] != '0)
    else $error("zero density without error flag");

  // an open output side never blocks a request
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input blocked with output free");

endmodule

bind mixture_pressure_temperature_core mpt_checker u_mpt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

### tb/mixture_pressure_temperature_core_tb.sv
// self-checking testbench for the gas mixture pressure and temperature core
module mixture_pressure_temperature_core_tb;

  localparam int  FB      = mpt_pkg::FRAC_BITS_DEFAULT;
  localparam int  LATENCY = 252 + 3 * FB;
  localparam int  SETTLE  = 48 + FB;
  localparam int  NPHASE  = 6;
  localparam int  NRAND   = 30;

  typedef struct {
    logic [mpt_pkg::MOM_W-1:0]  mom_x;
    logic [mpt_pkg::MOM_W-1:0]  mom_y;
    logic [mpt_pkg::MOM_W-1:0]  energy;
    logic [mpt_pkg::DENS_W-1:0] dens [mpt_pkg::SPECIES_MAX];
  } cell_t;

  typedef struct {
    logic [mpt_pkg::DENS_W-1:0] rho;
    logic [mpt_pkg::MOM_W-1:0]  pres;
    logic [mpt_pkg::MOM_W-1:0]  temp;
    logic                       err;
  } gas_state_t;

  class gas_state_scoreboard;
    bit [mpt_pkg::GAMMA_W-1:0] gamma_r [mpt_pkg::SPECIES_MAX];
    bit [mpt_pkg::GAS_W-1:0]   gas_r [mpt_pkg::SPECIES_MAX];
    gas_state_t                expected_states [$];
    int                        errors;

    function void set_reg(int idx, bit [mpt_pkg::CFG_W-1:0] val);
      if (idx[0] == mpt_pkg::REG_GAMMA) gamma_r[idx >> 1] = val[mpt_pkg::GAMMA_W-1:0];
      else gas_r[idx >> 1] = val;
    endfunction

    function void reset_regs();
      for (int s = 0; s < mpt_pkg::SPECIES_MAX; s++) begin
        gamma_r[s] = mpt_pkg::GAMMA_RESET;
        gas_r[s]   = mpt_pkg::GAS_RESET;
      end
    endfunction

    function bit [127:0] mag48(logic [mpt_pkg::MOM_W-1:0] raw, output bit neg);
      bit [127:0] r;
      r = 128'(raw);
      neg = raw[mpt_pkg::MOM_W-1];
      return neg ? ((128'd1 << 48) - r) : r;
    endfunction

    function bit [mpt_pkg::MOM_W-1:0] sat48(bit [127:0] m, bit neg,
                                            output bit [127:0] smag);
      bit [127:0] lim;
      lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      smag = (m > lim) ? lim : m;
      return neg ? mpt_pkg::MOM_W'((128'd1 << 48) - smag) : smag[mpt_pkg::MOM_W-1:0];
    endfunction

    function gas_state_t eos_predict(cell_t c);
      gas_state_t r;
      bit [127:0] rho, w, v, a, k, d, g, q, gm1, mx, my, em, kin, e, pm, pmag, tmag;
      bit mxn, myn, en, eneg;
      rho = 0; w = 0; v = 0;
      for (int s = 0; s < mpt_pkg::SPECIES_MAX; s++) rho += 128'(c.dens[s]);
      r.rho  = (rho > 128'(mpt_pkg::DENS_MAX)) ? mpt_pkg::DENS_MAX
             : rho[mpt_pkg::DENS_W-1:0];
      r.pres = 0;
      r.temp = 0;
      r.err  = 0;
      if (rho == 0) begin
        r.err = 1;
        return r;
      end
      for (int s = 0; s < mpt_pkg::SPECIES_MAX; s++) begin
        g = 128'(gamma_r[s]);
        a = (g > (128'd1 << FB)) ? g - (128'd1 << FB) : 128'd1;
        k = (128'(gas_r[s]) << FB) / a;
        d = 128'(c.dens[s]);
        v += d * k;
        w += d * 128'(gas_r[s]);
      end
      if (w == 0) return r;
      if (v == 0) gm1 = {64'd0, {64{1'b1}}};
      else begin
        q = (w << FB) / v;
        gm1 = (q[127:64] != 0) ? {64'd0, {64{1'b1}}} : q;
      end
      mx  = mag48(c.mom_x, mxn);
      my  = mag48(c.mom_y, myn);
      kin = (mx * mx + my * my) / (2 * rho);
      em  = mag48(c.energy, en);
      if (en) begin
        e = em + kin;
        eneg = 1;
      end else if (em >= kin) begin
        e = em - kin;
        eneg = 0;
      end else begin
        e = kin - em;
        eneg = 1;
      end
      if (gm1 == 0 || e == 0) pm = 0;
      else if (e[127:64] != 0) pm = 128'd1 << 64;
      else pm = (e * gm1) >> FB;
      r.pres = sat48(pm, eneg, pmag);
      pm = (pmag << (2 * FB)) / w;
      r.temp = sat48(pm, eneg && pmag != 0, tmag);
      return r;
    endfunction

    function void note_cell(cell_t c);
      expected_states.push_back(eos_predict(c));
    endfunction

    function void check_result(logic [mpt_pkg::OUT_W-1:0] data, logic user);
      gas_state_t x;
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected result, actual %h %b", $time, data, user);
        errors++;
        return;
      end
      x = expected_states.pop_front();
      if (data[46:0] !== x.rho) begin
        $display("%0t: density expected %h actual %h", $time, x.rho, data[46:0]);
        errors++;
      end
      if (data[94:47] !== x.pres) begin
        $display("%0t: pressure expected %h actual %h", $time, x.pres, data[94:47]);
        errors++;
      end
      if (data[142:95] !== x.temp) begin
        $display("%0t: temperature expected %h actual %h", $time, x.temp, data[142:95]);
        errors++;
      end
      if (user !== x.err) begin
        $display("%0t: error flag expected %b actual %b", $time, x.err, user);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 0;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [mpt_pkg::IN_W-1:0]    s_tdata;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [mpt_pkg::OUT_W-1:0]   m_tdata;
  logic                        m_tuser;
  logic                        cfg_wen;
  logic [mpt_pkg::IDX_W-1:0]   cfg_index;
  logic [mpt_pkg::CFG_W-1:0]   cfg_data;

  gas_state_scoreboard sb;
  bit burst_mode;
  bit hold_req;

  always #1 clk = ~clk;

  mixture_pressure_temperature_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic [mpt_pkg::MOM_W-1:0] rand_scaled48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0] >> $urandom_range(0, 47);
  endfunction

  task automatic send_cell(cell_t c);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {4'd0, c.dens[3], c.dens[2], c.dens[1], c.dens[0],
                 c.energy, c.mom_y, c.mom_x};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_cell(c);
  endtask

  task automatic write_regs(bit [mpt_pkg::CFG_W-1:0] vals [2*mpt_pkg::SPECIES_MAX]);
    s_tvalid <= 0;
    while (sb.expected_states.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    for (int i = 0; i < 2 * mpt_pkg::SPECIES_MAX; i++) begin
      cfg_wen   <= 1;
      cfg_index <= mpt_pkg::IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(i, vals[i]);
    end
    cfg_wen <= 0;
    repeat (SETTLE + 20) @(posedge clk);
  endtask

  function cell_t rand_cell();
    cell_t c;
    int mode;
    mode = $urandom_range(0, 19);
    c.mom_x  = rand_scaled48();
    c.mom_y  = rand_scaled48();
    c.energy = rand_scaled48();
    for (int s = 0; s < mpt_pkg::SPECIES_MAX; s++) begin
      c.dens[s] = ($urandom_range(0, 3) == 0) ? '0 : mpt_pkg::DENS_W'(rand_scaled48());
      if (mode == 1) c.dens[s] = '0;
      if (mode == 2) c.dens[s] = mpt_pkg::DENS_MAX;
    end
    return c;
  endfunction

  task automatic directed_cells();
    cell_t c;
    for (int i = 0; i < 20; i++) begin
      c.mom_x  = mpt_pkg::MOM_W'(i * 48'h1000000);
      c.mom_y  = '0;
      c.energy = 48'h0000_6400_0000;
      for (int s = 0; s < mpt_pkg::SPECIES_MAX; s++) begin
        c.dens[s] = (s == 0) ? 47'h100_0000 : '0;
      end
      case (i)
        0: c.dens[0] = '0;
        1: begin
          c.mom_x = mpt_pkg::MAG_NEG_MAX;
          c.mom_y = mpt_pkg::MAG_NEG_MAX;
        end
        2: begin
          c.mom_x = mpt_pkg::MAG_POS_MAX;
          c.mom_y = mpt_pkg::MAG_POS_MAX;
          c.energy = mpt_pkg::MAG_POS_MAX;
        end
        3: c.energy = mpt_pkg::MAG_NEG_MAX;
        4: c.energy = mpt_pkg::MAG_POS_MAX;
        5: for (int s = 0; s < mpt_pkg::SPECIES_MAX; s++) c.dens[s] = mpt_pkg::DENS_MAX;
        6: begin
          c.dens[0] = '0;
          c.dens[3] = 47'h1;
        end
        7: c.energy = 48'hFFFF_FFFF_FFFF;
        8: c.energy = '0;
        9: begin
          c.mom_x = '0;
          c.energy = '0;
        end
        10: c.dens[0] = 47'h1;
        11: for (int s = 0; s < mpt_pkg::SPECIES_MAX; s++) c.dens[s] = 47'h80_0000;
        12: begin
          c.mom_x = 48'hFFFF_FF00_0000;
          c.energy = 48'h1;
        end
        default: c = rand_cell();
      endcase
      send_cell(c);
    end
  endtask

  initial begin
    m_tready <= 0;
    forever begin
      int hold;
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_req) begin
        hold_req = 0;
        m_tready <= 0;
        repeat (1500) @(posedge clk);
        if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= 1;
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          m_tready <= 0;
          repeat (hold) @(posedge clk);
          m_tready <= 1;
        end else begin
          m_tready <= 1;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit [mpt_pkg::CFG_W-1:0] vals [2*mpt_pkg::SPECIES_MAX];
    sb = new();
    sb.reset_regs();
    burst_mode = 0;
    hold_req   = 0;
    rst       <= 1;
    s_tvalid  <= 0;
    s_tdata   <= '0;
    cfg_wen   <= 0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 0;
    repeat (SETTLE + 20) @(posedge clk);
    directed_cells();
    for (int ph = 0; ph < NPHASE; ph++) begin
      for (int s = 0; s < mpt_pkg::SPECIES_MAX; s++) begin
        case (ph)
          0: begin
            vals[2*s]   = 47'd16777217;
            vals[2*s+1] = mpt_pkg::DENS_MAX;
          end
          1: begin
            vals[2*s]   = 47'd50331648;
            vals[2*s+1] = 47'd1;
          end
          2: begin
            vals[2*s]   = 47'h7FFF_FC00_0000;
            vals[2*s+1] = (s == 2) ? 47'(rand_scaled48()) | 47'h1 : '0;
          end
          default: begin
            vals[2*s] = ($urandom_range(0, 3) == 0) ? 47'({$urandom, $urandom})
                        : 47'($urandom_range(16777217, 50331648));
            vals[2*s+1] = 47'(rand_scaled48());
          end
        endcase
      end
      write_regs(vals);
      if (ph == 0) begin
        burst_mode = 1;
        hold_req   = 1;
        repeat (400) send_cell(rand_cell());
        burst_mode = 0;
      end
      repeat (NRAND) send_cell(rand_cell());
    end
    s_tvalid <= 0;
    while (sb.expected_states.size() != 0) @(posedge clk);
    repeat (LATENCY + 50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mpt_pkg.sv
rtl/mpt_div.sv
rtl/mixture_pressure_temperature_core.sv
rtl/mpt_checker.sv
tb/mixture_pressure_temperature_core_tb.sv
